// ----- design/s2c_pkg.sv -----
`default_nettype none
package s2c_pkg;
    localparam int unsigned CordicSteps = 24;
    localparam int unsigned CordicW = 34;
    localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
    localparam logic signed [CordicW-1:0] Q30One = 34'sd1073741824;

    // Arctangent of 2^-i in binary-angle units.
    function automatic logic signed [CordicW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [CordicW-1:0] v;
        begin
            case (idx)
                5'd0: v = 34'sd536870912;
                5'd1: v = 34'sd316933406;
                5'd2: v = 34'sd167458907;
                5'd3: v = 34'sd85004756;
                5'd4: v = 34'sd42667331;
                5'd5: v = 34'sd21354465;
                5'd6: v = 34'sd10679838;
                5'd7: v = 34'sd5340245;
                5'd8: v = 34'sd2670163;
                5'd9: v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                5'd24: v = 34'sd41;
                5'd25: v = 34'sd20;
                5'd26: v = 34'sd10;
                5'd27: v = 34'sd5;
                5'd28: v = 34'sd3;
                5'd29: v = 34'sd1;
                5'd30: v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    // Round-half-up products: Q30 and Q16 scaling.
    function automatic logic signed [65:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = 68'(a) * 68'(b) + 68'sd536870912;
            return 66'(p >>> 30);
        end
    endfunction

    function automatic logic signed [65:0] mul16(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        begin
            p = 68'(a) * 68'(b) + 68'sd32768;
            return 66'(p >>> 16);
        end
    endfunction

    typedef struct packed {
        logic signed [31:0] radius;
        logic signed [31:0] lat_rate;
        logic signed [31:0] lon_rate;
        logic signed [31:0] radius_rate;
    } t_side;
endpackage
`default_nettype wire

// ----- design/s2c_cordic.sv -----
`default_nettype none
// Pipelined rotation CORDIC: one stage per step, plus fold and clamp stages.
module s2c_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_angle,
    output logic signed [33:0]      o_sin,
    output logic signed [33:0]      o_cos
);
    localparam int unsigned N = s2c_pkg::CordicSteps;
    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic               r_f [0:N];
    logic [31:0] fold;
    logic        flip;

    // Fold the angle into [-pi/2, pi/2).
    always_comb begin
        flip = i_angle[31] ^ i_angle[30];
        fold = {i_angle[31] ^ flip, i_angle[30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= s2c_pkg::CordicGain;
            r_y[0] <= '0;
            r_z[0] <= 34'(signed'(fold));
            r_f[0] <= flip;
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - s2c_pkg::atan_entry(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + s2c_pkg::atan_entry(5'(g));
                end
                r_f[g+1] <= r_f[g];
            end
        end
    end

    logic signed [33:0] cx, cy;
    always_comb begin
        cx = r_x[N];
        cy = r_y[N];
        if (cx > s2c_pkg::Q30One) cx = s2c_pkg::Q30One;
        if (cx < -s2c_pkg::Q30One) cx = -s2c_pkg::Q30One;
        if (cy > s2c_pkg::Q30One) cy = s2c_pkg::Q30One;
        if (cy < -s2c_pkg::Q30One) cy = -s2c_pkg::Q30One;
    end

    // Clamp and undo the fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_f[N] ? -cx : cx;
            o_sin <= r_f[N] ? -cy : cy;
        end
    end
endmodule
`default_nettype wire

// ----- design/s2c_math.sv -----
`default_nettype none
// Product and sum stages from sine and cosine to saturated outputs.
module s2c_math (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [33:0] i_sp,
    input  wire logic signed [33:0] i_cp,
    input  wire logic signed [33:0] i_st,
    input  wire logic signed [33:0] i_ct,
    input  wire s2c_pkg::t_side     i_side,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_vel_x,
    output logic signed [31:0]      o_vel_y,
    output logic signed [31:0]      o_vel_z,
    output logic                    o_clipped
);
    // Stage 1: A, B, cp*ct, cp*st, sp*dr.
    logic signed [33:0] r_a, r_b, r_cc, r_cs, r_sdr, r_st1, r_ct1;
    logic signed [31:0] r_dr1, r_dth1, r_dph1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= 34'(s2c_pkg::mul30(34'(i_side.radius), i_cp));
            r_b   <= 34'(s2c_pkg::mul30(34'(i_side.radius), i_sp));
            r_cc  <= 34'(s2c_pkg::mul30(i_cp, i_ct));
            r_cs  <= 34'(s2c_pkg::mul30(i_cp, i_st));
            r_sdr <= 34'(s2c_pkg::mul30(i_sp, 34'(i_side.radius_rate)));
            r_st1 <= i_st;
            r_ct1 <= i_ct;
            r_dr1 <= i_side.radius_rate;
            r_dth1 <= i_side.lon_rate;
            r_dph1 <= i_side.lat_rate;
        end
    end

    // Stage 2: positions and the second-level products.
    logic signed [33:0] r_px, r_py, r_pz, r_bc, r_bs;
    logic signed [33:0] r_ccdr, r_csdr, r_sdr2;
    logic signed [49:0] r_adp;
    logic signed [31:0] r_dth2, r_dph2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= 34'(s2c_pkg::mul30(r_a, r_ct1));
            r_py   <= 34'(s2c_pkg::mul30(r_a, r_st1));
            r_pz   <= r_b;
            r_bc   <= 34'(s2c_pkg::mul30(r_b, r_ct1));
            r_bs   <= 34'(s2c_pkg::mul30(r_b, r_st1));
            r_ccdr <= 34'(s2c_pkg::mul30(r_cc, 34'(r_dr1)));
            r_csdr <= 34'(s2c_pkg::mul30(r_cs, 34'(r_dr1)));
            r_adp  <= 50'(s2c_pkg::mul16(r_a, 34'(r_dph1)));
            r_sdr2 <= r_sdr;
            r_dth2 <= r_dth1;
            r_dph2 <= r_dph1;
        end
    end

    // Stage 3: rate products.
    logic signed [49:0] r_ydt, r_xdt, r_bcd, r_bsd;
    logic signed [33:0] r_px3, r_py3, r_pz3, r_ccdr3, r_csdr3;
    logic signed [50:0] r_vz3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ydt  <= 50'(s2c_pkg::mul16(r_py, 34'(r_dth2)));
            r_xdt  <= 50'(s2c_pkg::mul16(r_px, 34'(r_dth2)));
            r_bcd  <= 50'(s2c_pkg::mul16(r_bc, 34'(r_dph2)));
            r_bsd  <= 50'(s2c_pkg::mul16(r_bs, 34'(r_dph2)));
            r_px3  <= r_px;
            r_py3  <= r_py;
            r_pz3  <= r_pz;
            r_ccdr3 <= r_ccdr;
            r_csdr3 <= r_csdr;
            r_vz3  <= 51'(r_sdr2) + 51'(r_adp);
        end
    end

    function automatic logic [32:0] sat(input logic signed [51:0] v);
        begin
            if (v > 52'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
            if (v < -52'sd2147483648) return {1'b1, 32'h8000_0000};
            return {1'b0, v[31:0]};
        end
    endfunction

    logic [32:0] s0, s1, s2, s3, s4, s5;
    always_comb begin
        s0 = sat(52'(r_px3));
        s1 = sat(52'(r_py3));
        s2 = sat(52'(r_pz3));
        s3 = sat(52'(r_ccdr3) - 52'(r_ydt) - 52'(r_bcd));
        s4 = sat(52'(r_csdr3) + 52'(r_xdt) - 52'(r_bsd));
        s5 = sat(52'(r_vz3));
    end

    // Stage 4: sums and saturation.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos_x <= s0[31:0];
            o_pos_y <= s1[31:0];
            o_pos_z <= s2[31:0];
            o_vel_x <= s3[31:0];
            o_vel_y <= s4[31:0];
            o_vel_z <= s5[31:0];
            o_clipped <= s0[32] | s1[32] | s2[32] | s3[32] | s4[32] | s5[32];
        end
    end
endmodule
`default_nettype wire

// ----- design/spherical_to_cartesian_with_rates_unit.sv -----
`default_nettype none
// Spherical to Cartesian conversion with rates. One word is accepted every cycle
// while the output is not stalled; each word passes through the one-stage-per-step
// CORDIC pipelines and then four multiply and sum stages. The whole pipeline
// advances together, and stalls when the output register is full and not taken.
module spherical_to_cartesian_with_rates_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_lat_angle,
    input  wire logic signed [31:0] i_lon_angle,
    input  wire logic signed [31:0] i_radius,
    input  wire logic signed [31:0] i_lat_rate,
    input  wire logic signed [31:0] i_lon_rate,
    input  wire logic signed [31:0] i_radius_rate,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic signed [31:0]      o_vel_x,
    output logic signed [31:0]      o_vel_y,
    output logic signed [31:0]      o_vel_z,
    output logic                    o_clipped
);
    localparam int unsigned CDepth = s2c_pkg::CordicSteps + 2;
    localparam int unsigned Depth = CDepth + 4;

    logic en;
    logic [Depth-1:0] r_vld;
    assign en = !r_vld[Depth-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Depth-1];

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    // Side fields wait alongside the CORDIC stages.
    s2c_pkg::t_side r_side [0:CDepth-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{i_radius, i_lat_rate, i_lon_rate, i_radius_rate};
            for (int k = 1; k < CDepth; k++) r_side[k] <= r_side[k-1];
        end
    end

    logic signed [33:0] sp, cp, st, ct;
    s2c_cordic u_lat (.i_clk, .i_en(en), .i_angle(i_lat_angle), .o_sin(sp), .o_cos(cp));
    s2c_cordic u_lon (.i_clk, .i_en(en), .i_angle(i_lon_angle), .o_sin(st), .o_cos(ct));

    s2c_math u_math (
        .i_clk, .i_en(en), .i_sp(sp), .i_cp(cp), .i_st(st), .i_ct(ct),
        .i_side(r_side[CDepth-1]),
        .o_pos_x, .o_pos_y, .o_pos_z, .o_vel_x, .o_vel_y, .o_vel_z, .o_clipped
    );

    // A stalled output word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_clipped))
        else $error("output word changed while stalled");
    // Ready is low only when a word waits.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("pipeline stalled with no word waiting");
endmodule
`default_nettype wire

// ----- tb/spherical_to_cartesian_with_rates_unit_test.sv -----
`timescale 1ns / 1ps
module spherical_to_cartesian_with_rates_unit_test;

    localparam int Latency = s2c_pkg::CordicSteps + 6;
    localparam int StallLimit = 20000;

    typedef struct {
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic clip;
    } t_cart;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_lat_angle = '0, i_lon_angle = '0, i_radius = '0;
    logic signed [31:0] i_lat_rate = '0, i_lon_rate = '0, i_radius_rate = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z;
    logic o_clipped;

    t_cart cart_queue[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 1'b0;
    int quiet_cycles = 0;

    spherical_to_cartesian_with_rates_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Floor division by a power of two, with round half up added first.
    function automatic longint scale_down(longint a, longint b, int s);
        longint p;
        begin
            p = a * b + (64'sd1 <<< (s - 1));
            return p >>> s;
        end
    endfunction

    // Rotation-mode CORDIC over a folded binary angle; returns sine and cosine in Q1.30.
    task automatic cordic_sincos(input logic [31:0] ang, output longint s, output longint c);
        logic [31:0] u;
        bit flip;
        longint x, y, z, t, step;
        begin
            u = ang;
            flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
            if (flip) u[31] = ~u[31];
            x = 652032874;
            y = 0;
            z = longint'($signed(u));
            for (int i = 0; i < s2c_pkg::CordicSteps && i < 32; i++) begin
                step = longint'(s2c_pkg::atan_entry(i[4:0]));
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    x = t;
                    z -= step;
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    x = t;
                    z += step;
                end
            end
            if (x > 1073741824) x = 1073741824;
            if (x < -1073741824) x = -1073741824;
            if (y > 1073741824) y = 1073741824;
            if (y < -1073741824) y = -1073741824;
            if (flip) begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        end
    endtask

    function automatic logic signed [31:0] clamp32(longint v, ref bit clip);
        begin
            if (v > 64'sd2147483647) begin
                clip = 1'b1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648) begin
                clip = 1'b1;
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

    // Works out the Cartesian position and velocity for one word.
    task automatic predict_cartesian(input logic signed [31:0] lat, lon, r, dphi, dth, dr);
        longint sp, cp, st, ct, a, b, x, y, vx, vy, vz;
        bit clip;
        t_cart e;
        begin
            clip = 1'b0;
            cordic_sincos(lat, sp, cp);
            cordic_sincos(lon, st, ct);
            a = scale_down(r, cp, 30);
            b = scale_down(r, sp, 30);
            x = scale_down(a, ct, 30);
            y = scale_down(a, st, 30);
            vx = scale_down(scale_down(cp, ct, 30), dr, 30) - scale_down(y, dth, 16)
                - scale_down(scale_down(b, ct, 30), dphi, 16);
            vy = scale_down(scale_down(cp, st, 30), dr, 30) + scale_down(x, dth, 16)
                - scale_down(scale_down(b, st, 30), dphi, 16);
            vz = scale_down(sp, dr, 30) + scale_down(a, dphi, 16);
            e.px = clamp32(x, clip);
            e.py = clamp32(y, clip);
            e.pz = clamp32(b, clip);
            e.vx = clamp32(vx, clip);
            e.vy = clamp32(vy, clip);
            e.vz = clamp32(vz, clip);
            e.clip = clip;
            cart_queue.push_back(e);
        end
    endtask

    // Sends one word, idling beforehand at random, and predicts its result.
    // Valid stays high after acceptance until the next idle cycle or the end.
    task automatic send_word(input logic signed [31:0] lat, lon, r, dphi, dth, dr);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_lat_angle <= lat;
            i_lon_angle <= lon;
            i_radius <= r;
            i_lat_rate <= dphi;
            i_lon_rate <= dth;
            i_radius_rate <= dr;
            predict_cartesian(lat, lon, r, dphi, dth, dr);
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
    endtask

    // Receiver ready, with random idling and an optional long hold-off.
    always @(posedge i_clk) begin
        i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Compares every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (cart_queue.size() == 0) begin
                $display("%0t: unexpected result word", $realtime);
                errors++;
            end else begin
                t_cart e;
                e = cart_queue.pop_front();
                if ({o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z, o_clipped} !==
                    {e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.clip}) begin
                    $display("%0t: expected %h %h %h %h %h %h %b actual %h %h %h %h %h %h %b",
                             $realtime, e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.clip,
                             o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y, o_vel_z,
                             o_clipped);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        begin
            case ($urandom_range(5))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
                default: return $urandom;
            endcase
        end
    endfunction

    // Extremes, quadrant boundaries, latitude beyond the poles and negative distances.
    task automatic test_directed();
        logic signed [31:0] angs[8];
        begin
            angs = '{32'sh0, 32'sh40000000, 32'shc0000000, 32'sh80000000,
                     32'sh7fffffff, 32'sh3fffffff, 32'sh20000000, 32'sh60000000};
            foreach (angs[k])
                send_word(angs[k], angs[7 - k], 32'sh00010000, 32'sh00008000,
                          -32'sh00004000, 32'sh00020000);
            send_word(32'sh0, 32'sh0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff);
            send_word(32'sh0, 32'sh0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000);
            send_word(32'sh20000000, 32'sh20000000, -32'sh00050000, 32'sh7fffffff,
                      32'sh80000000, 32'sh0);
            send_word(32'sh80000000, 32'sh7fffffff, 32'shffffffff, 32'sh1, 32'shffffffff,
                      32'sh1);
            send_word(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
        end
    endtask

    task automatic test_random(input int count);
        begin
            repeat (count)
                send_word($urandom, $urandom, rand_word(), rand_word(), rand_word(),
                          rand_word());
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        begin
            fork
                begin
                    recv_hold = 1'b1;
                    repeat (3 * Latency) @(posedge i_clk);
                    recv_hold = 1'b0;
                end
                test_random(2 * Latency);
            join
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 30;
        recv_idle_pct = 62;
        test_directed();
        test_random(200);
        send_idle_pct = 62;
        recv_idle_pct = 30;
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(170);
        i_valid <= 1'b0;
        while (cart_queue.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
